// ----- hw/rtl/sha384_pkg.sv -----
// Shared types, constants and round functions for the SHA-384 engine.
package sha384_pkg;

    localparam int unsigned WordBits   = 64;
    localparam int unsigned BlockWords = 16;
    localparam int unsigned Rounds     = 80;
    localparam int unsigned DigestWords = 6;

    // Block fill position in bytes: 0..128.
    localparam logic [7:0] PadLimit = 8'd112;

    typedef logic [63:0] word_t;

    // Start and done handshake between sequencer and compression core.
    typedef struct packed {
        logic start;
        logic done;
    } core_ctl_t;

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t v;
        begin
            case (idx)
                3'd0: v = 64'hcbbb9d5dc1059ed8;
                3'd1: v = 64'h629a292a367cd507;
                3'd2: v = 64'h9159015a3070dd17;
                3'd3: v = 64'h152fecd8f70e5939;
                3'd4: v = 64'h67332667ffc00b31;
                3'd5: v = 64'h8eb44a8768581511;
                3'd6: v = 64'hdb0c2e0d64f98fa7;
                default: v = 64'h47b5481dbefa4fa4;
            endcase
            return v;
        end
    endfunction

    function automatic word_t round_k(input logic [6:0] r);
        word_t k;
        begin
            case (r)
                7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
                7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
                7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
                7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
                7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
                7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
                7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
                7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
                7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
                7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
                7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
                7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
                7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
                7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
                7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
                7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
                7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
                7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
                7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
                7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
                7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
                7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
                7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
                7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
                7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
                7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
                7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
                7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
                7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
                7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
                7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
                7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
                7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
                7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
                7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
                7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
                7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
                7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
                7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
                7'd78: k = 64'h5fcb6fab3ad6faec; default: k = 64'h6c44198c4a475817;
            endcase
            return k;
        end
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        begin
            return (x >> n) | (x << (WordBits - n));
        end
    endfunction

endpackage

// ----- hw/rtl/sha384_hash_engine_unit.sv -----
// Top level of the SHA-384 engine: byte packing, padding sequencer, digest output.
//
//  channel | dir | tdata                                  | tuser
//  s_axis  | in  | data_word[63:0]                        | valid_bytes[3:0], tlast=last_chunk
//  m_axis  | out | digest_word[63:0]                      | word_index[2:0], tlast=last_word
//
// A non-last item is packed byte by byte; each time a 128-byte block fills, it is
// compressed in 80 rounds in the shared round unit and the chain is updated.
// A last item takes one or two compressions, then six output words.
// Reset loads the SHA-384 initial values; no input is taken while compressing
// or while digest words are pending on the output.
module sha384_hash_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // data_word
    input  logic [3:0]  s_axis_tuser,   // valid_bytes
    input  logic        s_axis_tlast,   // last_chunk
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // last_word
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_COMP  = 6'b000010,
        ST_PAD   = 6'b000100,
        ST_FIN   = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_PACK  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    sha384_pkg::word_t blk_reg [sha384_pkg::BlockWords];
    logic [7:0]  fill_reg;
    logic [63:0] bits_reg;
    sha384_pkg::word_t chain_reg [8];
    logic        last_reg;     // current compression is a final (padding) one
    logic        two_reg;      // final needs an extra block
    logic [63:0] hold_data_reg;
    logic [3:0]  hold_cnt_reg;
    logic [3:0]  hold_pos_reg;
    logic        hold_last_reg;
    logic [2:0]  out_idx_reg;

    logic [1023:0] block_bits;
    sha384_pkg::word_t core_state [8];
    sha384_pkg::core_ctl_t ctl;
    logic accept;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        for (int i = 0; i < 16; i++)
            block_bits[1023 - 64*i -: 64] = blk_reg[i];
    end

    assign ctl.start = (state_reg == ST_PACK) && (fill_reg == 8'd128) ||
                       (state_reg == ST_PAD) || (state_reg == ST_FIN);

    sha384_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctl.start),
        .block     (block_bits),
        .chain_in  (chain_reg),
        .state_out (core_state),
        .done      (ctl.done)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept) state_next = ST_PACK;
            ST_PACK:
                // one byte per cycle; compress when the block fills
                if (fill_reg == 8'd128) state_next = ST_COMP;
                else if (hold_pos_reg == hold_cnt_reg)
                    state_next = hold_last_reg ? ST_PAD : ST_IDLE;
            ST_PAD:
                state_next = ST_COMP;
            ST_FIN:
                state_next = ST_COMP;
            ST_COMP:
                if (ctl.done)
                begin
                    if (!last_reg) state_next = ST_PACK;
                    else if (two_reg) state_next = ST_FIN;
                    else state_next = ST_EMIT;
                end
            ST_EMIT:
                if (m_axis_tready && out_idx_reg ==
                    3'(sha384_pkg::DigestWords - 1))
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            bits_reg  <= '0;
            last_reg  <= 1'b0;
            two_reg   <= 1'b0;
            out_idx_reg <= '0;
            hold_cnt_reg <= '0;
            hold_pos_reg <= '0;
            hold_last_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= sha384_pkg::init_hash(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                    if (accept)
                    begin
                        hold_cnt_reg  <= (s_axis_tuser > 4'd8) ? 4'd8 : s_axis_tuser;
                        hold_pos_reg  <= '0;
                        hold_last_reg <= s_axis_tlast;
                        bits_reg <= bits_reg + {57'd0,
                            ((s_axis_tuser > 4'd8) ? 4'd8 : s_axis_tuser), 3'd0};
                    end
                ST_PACK:
                    if (fill_reg != 8'd128 && hold_pos_reg != hold_cnt_reg)
                    begin
                        fill_reg <= fill_reg + 8'd1;
                        hold_pos_reg <= hold_pos_reg + 4'd1;
                    end
                    else if (fill_reg != 8'd128 && hold_last_reg)
                    begin
                        last_reg <= 1'b1;
                        two_reg  <= (fill_reg >= sha384_pkg::PadLimit);
                    end
                ST_COMP:
                    if (ctl.done)
                    begin
                        for (int i = 0; i < 8; i++)
                            chain_reg[i] <= chain_reg[i] + core_state[i];
                        if (!last_reg) fill_reg <= '0;
                        else if (two_reg) two_reg <= 1'b0;
                    end
                ST_EMIT:
                    if (m_axis_tready)
                    begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'(sha384_pkg::DigestWords - 1))
                        begin
                            out_idx_reg <= '0;
                            fill_reg <= '0;
                            bits_reg <= '0;
                            last_reg <= 1'b0;
                            for (int i = 0; i < 8; i++)
                                chain_reg[i] <= sha384_pkg::init_hash(3'(i));
                        end
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept)
            hold_data_reg <= s_axis_tdata;
        else if (state_reg == ST_PACK && fill_reg != 8'd128 &&
                 hold_pos_reg != hold_cnt_reg)
        begin
            blk_reg[fill_reg[6:3]][{~fill_reg[2:0], 3'b000} +: 8] <= hold_data_reg[63:56];
            hold_data_reg <= {hold_data_reg[55:0], 8'd0};
        end
        else if (state_reg == ST_PACK && fill_reg != 8'd128 && hold_last_reg)
        begin
            // pad: marker, zeros, length in the last word when it fits
            for (int i = 0; i < sha384_pkg::BlockWords; i++)
            begin
                if (4'(i) == fill_reg[6:3])
                    blk_reg[i] <= (blk_reg[i] &
                        ~(64'hffff_ffff_ffff_ffff >> {fill_reg[2:0], 3'b000})) |
                        (64'h8000_0000_0000_0000 >> {fill_reg[2:0], 3'b000});
                else if (i == sha384_pkg::BlockWords - 1 &&
                         fill_reg < sha384_pkg::PadLimit)
                    blk_reg[i] <= bits_reg;
                else if (4'(i) > fill_reg[6:3])
                    blk_reg[i] <= '0;
            end
        end
        else if (state_reg == ST_COMP && ctl.done && last_reg && two_reg)
        begin
            for (int i = 0; i < sha384_pkg::BlockWords - 1; i++)
                blk_reg[i] <= '0;
            blk_reg[sha384_pkg::BlockWords - 1] <= bits_reg;
        end
    end

    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tdata  = chain_reg[out_idx_reg];
    assign m_axis_tuser  = out_idx_reg;
    assign m_axis_tlast  = (out_idx_reg == 3'(sha384_pkg::DigestWords - 1));

endmodule

// ----- hw/rtl/sha384_core.sv -----
// One-round-per-cycle SHA-512 compression core with rolling schedule window.
module sha384_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1023:0]          block,     // word 0 in the top bits
    input  sha384_pkg::word_t      chain_in [8],
    output sha384_pkg::word_t      state_out [8],
    output logic                   done
);

    sha384_pkg::word_t w_reg [16];
    sha384_pkg::word_t v_reg [8];
    logic [6:0] round_reg;
    logic busy_reg;
    logic done_reg;

    sha384_pkg::word_t w15, w2, w_cur, s0, s1, sig1, sig0, ch, maj, t1, t2;

    always_comb
    begin
        w15 = w_reg[1];
        w2  = w_reg[14];
        s0 = sha384_pkg::rotr(w15, 1) ^ sha384_pkg::rotr(w15, 8) ^ (w15 >> 7);
        s1 = sha384_pkg::rotr(w2, 19) ^ sha384_pkg::rotr(w2, 61) ^ (w2 >> 6);
        // the window head is already the word for this round
        w_cur = w_reg[0];
        sig1 = sha384_pkg::rotr(v_reg[4], 14) ^ sha384_pkg::rotr(v_reg[4], 18)
             ^ sha384_pkg::rotr(v_reg[4], 41);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        sig0 = sha384_pkg::rotr(v_reg[0], 28) ^ sha384_pkg::rotr(v_reg[0], 34)
             ^ sha384_pkg::rotr(v_reg[0], 39);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1 = v_reg[7] + sig1 + ch + sha384_pkg::round_k(round_reg) + w_cur;
        t2 = sig0 + maj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (round_reg == 7'(sha384_pkg::Rounds - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                round_reg <= round_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= block[1023 - 64*i -: 64];
            for (int i = 0; i < 8; i++)
                v_reg[i] <= chain_in[i];
        end
        else if (busy_reg)
        begin
            // shift window; new schedule word enters at the tail
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_reg[0] + s0 + w_reg[9] + s1;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign state_out = v_reg;
    assign done = done_reg;

endmodule
